FILE: rtl/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg
// Shared sizes, codes and index helpers for the deque with search.
// ----------------------------------------------------------------------------
package dws_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int POS_W  = 4;
   localparam int FILL_W = 5;

   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_BACK  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_SEARCH     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_SEARCH,
      ST_DONE
   } state_type;

   // circular slot at a given distance from the front
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/dws_ram.sv
// ----------------------------------------------------------------------------
// dws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of 32-bit words with a front-to-back search.
// ----------------------------------------------------------------------------
// One beat is handled at a time: req_tready is high only while the block is
// idle. Words live in a single-port-read RAM addressed circularly from a front
// index. A push passes the exec and done states, a pop exec, pop-wait and
// done; a search reads stored words from the front, one per cycle through
// the one RAM read port into the shared 32-bit comparator, until a match or
// the last word. Full pushes and empty pops or searches go from exec to done.
// Another beat can be accepted while the result waits in the output register.
module deque_with_search
   import dws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // position, popped_value, fill_count, zero pad
   output logic [1:0]  rsp_tuser    // status
);

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        front_ff, front_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   action_type              op_ff, op_in;
   logic [DATA_W-1:0]       key_ff, key_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   status_type              res_status_ff, res_status_in;
   logic [IDX_W-1:0]        res_pos_ff, res_pos_in;
   logic [DATA_W-1:0]       res_popped_ff, res_popped_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [DATA_W-1:0]       rsp_popped_ff, rsp_popped_in;
   logic [FILL_W-1:0]       rsp_fill_ff, rsp_fill_in;

   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic                    ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [DATA_W-1:0]       ram_rd_data;

   logic                    is_full;
   logic                    is_empty;
   logic                    srch_hit;
   logic                    srch_last;
   logic                    out_free;
   logic [IDX_W-1:0]        front_dec;
   logic [IDX_W+POS_W-1:0]  pos_ext;
   logic [CNT_W+FILL_W-1:0] fill_ext;

   dws_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign srch_hit  = (ram_rd_data == key_ff);
   assign srch_last = ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == count_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : (front_ff - IDX_W'(1));
   assign pos_ext   = {{POS_W{1'b0}}, res_pos_ff};
   assign fill_ext  = {{FILL_W{1'b0}}, count_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_fill_ff, rsp_popped_ff, rsp_pos_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               ACT_POP_FRONT: state_in = is_empty ? ST_DONE : ST_POP_WAIT;
               ACT_SEARCH:    state_in = is_empty ? ST_DONE : ST_SEARCH;
               default:       state_in = ST_DONE;
            endcase
         end
         ST_POP_WAIT: state_in = ST_DONE;
         ST_SEARCH: begin
            if (srch_hit || srch_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_popped_in = res_popped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_fill_in   = rsp_fill_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = front_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = front_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = action_type'(req_tuser);
               key_in = req_tdata;
            end
         end
         ST_EXEC: begin
            res_status_in = STAT_OK;
            res_pos_in    = '0;
            res_popped_in = '0;
            cmp_idx_in    = '0;
            case (op_ff)
               ACT_PUSH_FRONT: begin
                  if (is_full) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = front_dec;
                     front_in    = front_dec;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               ACT_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = slot_of(front_ff, count_ff[IDX_W-1:0]);
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               ACT_POP_FRONT: begin
                  if (is_empty) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     ram_rd_en = 1'b1;
                  end
               end
               default: begin
                  if (is_empty) begin
                     res_status_in = STAT_NOT_FOUND;
                  end else begin
                     ram_rd_en = 1'b1;
                  end
               end
            endcase
         end
         ST_POP_WAIT: begin
            res_popped_in = ram_rd_data;
            front_in      = slot_of(front_ff, IDX_W'(1));
            count_in      = count_ff - CNT_W'(1);
         end
         ST_SEARCH: begin
            if (srch_hit) begin
               res_status_in = STAT_OK;
               res_pos_in    = cmp_idx_ff;
            end else if (srch_last) begin
               res_status_in = STAT_NOT_FOUND;
               res_pos_in    = '0;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_of(front_ff, cmp_idx_ff + IDX_W'(1));
               cmp_idx_in  = cmp_idx_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = pos_ext[POS_W-1:0];
               rsp_popped_in = res_popped_ff;
               rsp_fill_in   = fill_ext[FILL_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_popped_ff <= res_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

endmodule
